[rtl/css_pkg.sv]
package css_pkg;

   // message type codes, shared by requests and responses
   localparam logic [4:0] MSG_NONE  = 5'd0;
   localparam logic [4:0] MSG_SDP   = 5'd1;
   localparam logic [4:0] MSG_V2S   = 5'd2;
   localparam logic [4:0] MSG_APP   = 5'd3;
   localparam logic [4:0] MSG_SETUP = 5'd4;
   localparam logic [4:0] MSG_SDISC = 5'd5;
   localparam logic [4:0] MSG_PSEL  = 5'd6;
   localparam logic [4:0] MSG_SDET  = 5'd7;
   localparam logic [4:0] MSG_AUTH  = 5'd8;
   localparam logic [4:0] MSG_CPD   = 5'd9;
   localparam logic [4:0] MSG_PDEL  = 5'd10;
   localparam logic [4:0] MSG_CSTAT = 5'd11;
   localparam logic [4:0] MSG_STOP  = 5'd12;
   localparam logic [4:0] MSG_CABLE = 5'd13;
   localparam logic [4:0] MSG_PRE   = 5'd14;
   localparam logic [4:0] MSG_CDEM  = 5'd15;
   localparam logic [4:0] MSG_WELD  = 5'd16;

   // session state codes
   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_AWAIT = 5'd1;
   localparam logic [4:0] ST_SDP   = 5'd2;
   localparam logic [4:0] ST_APP   = 5'd3;
   localparam logic [4:0] ST_SETUP = 5'd4;
   localparam logic [4:0] ST_SDISC = 5'd5;
   localparam logic [4:0] ST_SDET  = 5'd6;
   localparam logic [4:0] ST_PSEL  = 5'd7;
   localparam logic [4:0] ST_AUTH  = 5'd8;
   localparam logic [4:0] ST_CPD   = 5'd9;
   localparam logic [4:0] ST_PDEL  = 5'd10;
   localparam logic [4:0] ST_CSTAT = 5'd11;
   localparam logic [4:0] ST_STOP  = 5'd12;
   localparam logic [4:0] ST_CABLE = 5'd13;
   localparam logic [4:0] ST_PRE   = 5'd14;
   localparam logic [4:0] ST_CDEM  = 5'd15;
   localparam logic [4:0] ST_WELD  = 5'd16;
   localparam logic [4:0] ST_FAIL  = 5'd17;
   localparam logic [4:0] ST_FIN   = 5'd18;

   // one poll word
   typedef struct packed {
      logic       run;
      logic [4:0] msg_type;
      logic       msg_is_request;
      logic       client_connected;
      logic       tls_requested;
      logic       dialect_found;
      logic [7:0] dialect_schema;
   } css_req_type;

   // one result word
   typedef struct packed {
      logic        resp_valid;
      logic [4:0]  resp_type;
      logic        resp_ok;
      logic        resp_tls;
      logic [7:0]  resp_schema;
      logic [63:0] session_id;
      logic [4:0]  state_now;
      logic        done_res;
      logic        close_link;
      logic        unexpected;
      logic        last;
   } css_rsp_type;

   // what the pass logic sees of the session
   typedef struct packed {
      logic [4:0] state;
      logic       entered;
      logic       tls_in_use;
      logic       schema_valid;
      logic [7:0] schema;
      logic       provide_tls;
      logic       first;
   } css_pass_in_type;

   // what one pass decides
   typedef struct packed {
      logic [4:0] next_state;
      logic       entered;
      logic       tls_in_use;
      logic       schema_valid;
      logic [7:0] schema;
      logic       counter_inc;
      logic       again;
      logic       resp_valid;
      logic [4:0] resp_type;
      logic       resp_ok;
      logic       resp_tls;
      logic [7:0] resp_schema;
      logic       done_res;
      logic       close_link;
      logic       unexpected;
   } css_pass_out_type;

   // response sent on fresh entry into an answering state
   function automatic logic [4:0] answer_type(input logic [4:0] st);
      logic [4:0] rt;
      begin
         case (st)
            ST_SDP:   rt = MSG_SDP;
            ST_APP:   rt = MSG_APP;
            ST_SETUP: rt = MSG_SETUP;
            ST_SDISC: rt = MSG_SDISC;
            ST_SDET:  rt = MSG_SDET;
            ST_PSEL:  rt = MSG_PSEL;
            ST_AUTH:  rt = MSG_AUTH;
            ST_CPD:   rt = MSG_CPD;
            ST_PDEL:  rt = MSG_PDEL;
            ST_CSTAT: rt = MSG_CSTAT;
            ST_STOP:  rt = MSG_STOP;
            ST_CABLE: rt = MSG_CABLE;
            ST_PRE:   rt = MSG_PRE;
            ST_CDEM:  rt = MSG_CDEM;
            ST_WELD:  rt = MSG_WELD;
            default:  rt = MSG_NONE;
         endcase
         return rt;
      end
   endfunction

endpackage

[rtl/css_req_if.sv]
interface css_req_if;
   logic                valid;
   logic                ready;
   css_pkg::css_req_type data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

[rtl/css_rsp_if.sv]
interface css_rsp_if;
   logic                valid;
   logic                ready;
   css_pkg::css_rsp_type data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

[rtl/css_pass_logic.sv]
module css_pass_logic (
   input  css_pkg::css_pass_in_type  ctl,
   input  css_pkg::css_req_type      word,
   output css_pkg::css_pass_out_type res
);

   logic [4:0] msg;
   logic [4:0] st;
   logic [4:0] nx;
   logic       re;
   logic       early;

   always_comb begin
      st = ctl.state;
      // second pass of a poll sees no message
      msg = ctl.first ? word.msg_type : css_pkg::MSG_NONE;
      early = 1'b0;
      res = '0;
      res.tls_in_use = ctl.tls_in_use;
      res.schema_valid = ctl.schema_valid;
      res.schema = ctl.schema;

      // message arrival: drop or capture negotiation data
      if (msg != css_pkg::MSG_NONE) begin
         if (st == css_pkg::ST_IDLE || st == css_pkg::ST_FIN) begin
            msg = css_pkg::MSG_NONE;
            early = 1'b1;
         end else if (!word.msg_is_request && msg != css_pkg::MSG_V2S) begin
            msg = css_pkg::MSG_NONE;
            early = 1'b1;
         end else if (msg == css_pkg::MSG_SDP) begin
            res.tls_in_use = word.tls_requested & ctl.provide_tls;
         end else if (msg == css_pkg::MSG_APP) begin
            res.schema_valid = word.dialect_found;
            res.schema = word.dialect_found ? word.dialect_schema : 8'd0;
         end
      end

      nx = st;
      re = 1'b0;
      res.unexpected = early;

      // response on fresh entry consumes the pending message
      if (ctl.entered && (st inside {[css_pkg::ST_SDP:css_pkg::ST_WELD]})) begin
         res.resp_valid = 1'b1;
         res.resp_type = css_pkg::answer_type(st);
         if (st == css_pkg::ST_SDP) begin
            res.resp_tls = res.tls_in_use;
         end else if (st == css_pkg::ST_APP) begin
            if (res.schema_valid) begin
               res.resp_ok = 1'b1;
               res.resp_schema = res.schema;
            end else begin
               nx = css_pkg::ST_FAIL;
            end
         end else if (st == css_pkg::ST_SETUP) begin
            res.counter_inc = 1'b1;
         end
         msg = css_pkg::MSG_NONE;
      end

      // transitions
      case (st)
         css_pkg::ST_IDLE: begin
            if (word.run) nx = css_pkg::ST_AWAIT;
         end
         css_pkg::ST_AWAIT: begin
            if (msg == css_pkg::MSG_SDP) begin
               msg = css_pkg::MSG_NONE;
               nx = css_pkg::ST_SDP;
            end else if (msg == css_pkg::MSG_V2S) begin
               res.resp_valid = 1'b1;
               res.resp_type = css_pkg::MSG_V2S;
               msg = css_pkg::MSG_NONE;
            end
         end
         css_pkg::ST_SDP: begin
            if (msg == css_pkg::MSG_APP) nx = css_pkg::ST_APP;
         end
         css_pkg::ST_APP: begin
            if (msg == css_pkg::MSG_SETUP) nx = css_pkg::ST_SETUP;
         end
         css_pkg::ST_SETUP: begin
            if (msg == css_pkg::MSG_SDISC) nx = css_pkg::ST_SDISC;
         end
         css_pkg::ST_SDISC: begin
            if (msg == css_pkg::MSG_PSEL) nx = css_pkg::ST_PSEL;
            else if (msg == css_pkg::MSG_SDET) nx = css_pkg::ST_SDET;
         end
         css_pkg::ST_SDET: begin
            if (msg == css_pkg::MSG_PSEL) nx = css_pkg::ST_PSEL;
         end
         css_pkg::ST_PSEL: begin
            if (msg == css_pkg::MSG_AUTH) nx = css_pkg::ST_AUTH;
         end
         css_pkg::ST_AUTH: begin
            if (msg == css_pkg::MSG_AUTH) re = 1'b1;
            else if (msg == css_pkg::MSG_CPD) nx = css_pkg::ST_CPD;
         end
         css_pkg::ST_CPD: begin
            if (msg == css_pkg::MSG_PDEL) nx = css_pkg::ST_PDEL;
            else if (msg == css_pkg::MSG_CABLE) nx = css_pkg::ST_CABLE;
         end
         css_pkg::ST_PDEL: begin
            if (msg == css_pkg::MSG_CPD) nx = css_pkg::ST_CPD;
            else if (msg == css_pkg::MSG_CSTAT) nx = css_pkg::ST_CSTAT;
            else if (msg == css_pkg::MSG_STOP) nx = css_pkg::ST_STOP;
            else if (msg == css_pkg::MSG_CDEM) nx = css_pkg::ST_CDEM;
            else if (msg == css_pkg::MSG_WELD) nx = css_pkg::ST_WELD;
         end
         css_pkg::ST_CSTAT: begin
            if (msg == css_pkg::MSG_CSTAT) re = 1'b1;
            else if (msg == css_pkg::MSG_PDEL) nx = css_pkg::ST_PDEL;
         end
         css_pkg::ST_STOP: begin
            if (!word.client_connected) nx = css_pkg::ST_FIN;
         end
         css_pkg::ST_CABLE: begin
            if (msg == css_pkg::MSG_CABLE) re = 1'b1;
            else if (msg == css_pkg::MSG_PRE) nx = css_pkg::ST_PRE;
         end
         css_pkg::ST_PRE: begin
            if (msg == css_pkg::MSG_PRE) re = 1'b1;
            else if (msg == css_pkg::MSG_PDEL) nx = css_pkg::ST_PDEL;
         end
         css_pkg::ST_CDEM: begin
            if (msg == css_pkg::MSG_CDEM) re = 1'b1;
            else if (msg == css_pkg::MSG_PDEL) nx = css_pkg::ST_PDEL;
         end
         css_pkg::ST_WELD: begin
            if (msg == css_pkg::MSG_WELD) re = 1'b1;
            else if (msg == css_pkg::MSG_STOP) nx = css_pkg::ST_STOP;
         end
         css_pkg::ST_FAIL: begin
            res.close_link = ctl.entered;
            res.done_res = 1'b1;
            if (!word.run) nx = css_pkg::ST_IDLE;
         end
         css_pkg::ST_FIN: begin
            res.done_res = 1'b1;
            if (!word.run) nx = css_pkg::ST_IDLE;
         end
         default: begin
         end
      endcase

      // a message that led nowhere is flagged
      if (nx == st && !re && msg != css_pkg::MSG_NONE) res.unexpected = 1'b1;

      // lost link in a mid-session state
      if (!word.client_connected &&
          !(st inside {css_pkg::ST_IDLE, css_pkg::ST_AWAIT, css_pkg::ST_SDP,
                       css_pkg::ST_STOP, css_pkg::ST_FAIL, css_pkg::ST_FIN}))
         nx = css_pkg::ST_FAIL;

      res.next_state = nx;
      res.entered = re || (nx != st);
      res.again = res.entered && ctl.first;
   end

endmodule

[rtl/charger_session_sequencer.sv]
// channel   dir   handshake     word
// req_port  in    valid/ready   css_req_type (one poll)
// rsp_port  out   valid/ready   css_rsp_type (one result per pass)
// csr_*     in    write enable  provide_tls
//
// a poll yields a single word, or two words when its first pass enters a state;
// the one pass unit runs both passes, one per cycle unless the result stalls,
// between the poll register and the result register
// reset clears the session state, provide_tls to 1 and both valid flags
// a stalled result holds in its register while the next poll is taken in
module charger_session_sequencer (
   input  logic            clock,
   input  logic            reset,
   css_req_if.sink         req_port,
   css_rsp_if.source       rsp_port,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);

   css_pkg::css_req_type      req_ff, req_in;
   logic                      req_valid_ff, req_valid_in;
   logic                      phase_ff, phase_in;
   css_pkg::css_rsp_type      rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [4:0]                state_ff, state_in;
   logic                      entered_ff, entered_in;
   logic                      tls_ff, tls_in;
   logic                      schema_valid_ff, schema_valid_in;
   logic [7:0]                schema_ff, schema_in;
   logic [63:0]               counter_ff, counter_in;
   logic                      provide_tls_ff, provide_tls_in;

   css_pkg::css_pass_in_type  pass_ctl;
   css_pkg::css_pass_out_type pass_res;
   logic                      fire;
   logic                      accept;

   // pass unit
   assign pass_ctl.state = state_ff;
   assign pass_ctl.entered = entered_ff;
   assign pass_ctl.tls_in_use = tls_ff;
   assign pass_ctl.schema_valid = schema_valid_ff;
   assign pass_ctl.schema = schema_ff;
   assign pass_ctl.provide_tls = provide_tls_ff;
   assign pass_ctl.first = !phase_ff;

   css_pass_logic u_pass (
      .ctl  (pass_ctl),
      .word (req_ff),
      .res  (pass_res)
   );

   // handshake
   assign fire = req_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign req_port.ready = !req_valid_ff || (fire && !pass_res.again);
   assign accept = req_port.valid && req_port.ready;
   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.data = rsp_ff;

   // next values
   always_comb begin
      req_in = req_ff;
      req_valid_in = req_valid_ff;
      phase_in = phase_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      state_in = state_ff;
      entered_in = entered_ff;
      tls_in = tls_ff;
      schema_valid_in = schema_valid_ff;
      schema_in = schema_ff;
      counter_in = counter_ff;
      provide_tls_in = csr_wr_en ? csr_wr_data : provide_tls_ff;

      if (rsp_port.ready) rsp_valid_in = 1'b0;

      if (fire) begin
         state_in = pass_res.next_state;
         entered_in = pass_res.entered;
         tls_in = pass_res.tls_in_use;
         schema_valid_in = pass_res.schema_valid;
         schema_in = pass_res.schema;
         if (pass_res.counter_inc) counter_in = counter_ff + 64'd1;

         rsp_valid_in = 1'b1;
         rsp_in.resp_valid = pass_res.resp_valid;
         rsp_in.resp_type = pass_res.resp_type;
         rsp_in.resp_ok = pass_res.resp_ok;
         rsp_in.resp_tls = pass_res.resp_tls;
         rsp_in.resp_schema = pass_res.resp_schema;
         rsp_in.session_id = counter_in;
         rsp_in.state_now = pass_res.next_state;
         rsp_in.done_res = pass_res.done_res;
         rsp_in.close_link = pass_res.close_link;
         rsp_in.unexpected = pass_res.unexpected;
         rsp_in.last = !pass_res.again;

         if (pass_res.again) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            req_valid_in = 1'b0;
         end
      end

      if (accept) begin
         req_in = req_port.data;
         req_valid_in = 1'b1;
      end
   end

   // control and session state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         phase_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff <= css_pkg::ST_IDLE;
         entered_ff <= 1'b1;
         tls_ff <= 1'b0;
         schema_valid_ff <= 1'b0;
         schema_ff <= 8'd0;
         counter_ff <= 64'd0;
         provide_tls_ff <= 1'b1;
      end else begin
         req_valid_ff <= req_valid_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff <= state_in;
         entered_ff <= entered_in;
         tls_ff <= tls_in;
         schema_valid_ff <= schema_valid_in;
         schema_ff <= schema_in;
         counter_ff <= counter_in;
         provide_tls_ff <= provide_tls_in;
      end
   end

   // word registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // second pass only with a poll held
   assert property (@(posedge clock) disable iff (reset) phase_ff |-> req_valid_ff)
      else $error("second pass pending without a poll");

   // a first pass that enters a state is followed by the second pass
   assert property (@(posedge clock) disable iff (reset)
      fire && !phase_ff && pass_res.again |=> phase_ff && req_valid_ff)
      else $error("second pass lost");

   // the second pass always closes the poll
   assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff |=> rsp_ff.last && rsp_valid_ff)
      else $error("second pass word not marked last");

   // the state never leaves the defined codes
   assert property (@(posedge clock) disable iff (reset) state_ff <= css_pkg::ST_FIN)
      else $error("undefined session state");

   // close request only with a done result, as the failure state gives
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.close_link |-> rsp_ff.done_res)
      else $error("close request outside failure");

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_POLLS  = 270;
   localparam int SHOWN_ERRORS = 40;
   localparam logic [4:0] MSG_TOP_CODE = 5'd31;

   typedef struct {
      css_pkg::css_req_type poll;
      bit                   pinned;
      css_pkg::css_rsp_type first_word;
   } dir_row_type;

   logic clock       = 1'b0;
   logic reset       = 1'b1;
   logic csr_wr_en   = 1'b0;
   logic csr_wr_data = 1'b0;

   css_req_if req_bus();
   css_rsp_if rsp_bus();

   charger_session_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // session tracked on the testbench side
   logic [4:0]  sess_state       = css_pkg::ST_IDLE;
   logic        sess_entered     = 1'b1;
   logic        tls_granted      = 1'b0;
   logic        dialect_ok       = 1'b0;
   logic [7:0]  dialect_schema_q = 8'd0;
   logic [63:0] session_count    = 64'd0;
   logic        provide_tls_cfg  = 1'b1;

   css_pkg::css_rsp_type expected_words[$];
   css_pkg::css_req_type session_plan[$];
   dir_row_type          dir_rows[$];
   int                   err_count     = 0;
   int                   polls_taken   = 0;
   int                   cycle_count   = 0;
   int                   send_idle_pct = 0;
   int                   rsp_stall_pct = 0;
   int                   words_before;
   css_pkg::css_rsp_type want;
   css_pkg::css_rsp_type got;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected words of one poll: arrival, then one or two passes
   function automatic void predict_poll(input css_pkg::css_req_type p);
      logic [4:0]           msg;
      logic [4:0]           st;
      logic [4:0]           nx;
      logic                 early;
      logic                 re;
      logic                 ent;
      logic                 again;
      int                   pass;
      css_pkg::css_rsp_type w;
      msg   = p.msg_type;
      early = 1'b0;
      if (msg != css_pkg::MSG_NONE) begin
         if (sess_state == css_pkg::ST_IDLE || sess_state == css_pkg::ST_FIN) begin
            msg   = css_pkg::MSG_NONE;
            early = 1'b1;
         end else if (!p.msg_is_request && msg != css_pkg::MSG_V2S) begin
            msg   = css_pkg::MSG_NONE;
            early = 1'b1;
         end else if (msg == css_pkg::MSG_SDP) begin
            tls_granted = p.tls_requested & provide_tls_cfg;
         end else if (msg == css_pkg::MSG_APP) begin
            dialect_ok       = p.dialect_found;
            dialect_schema_q = p.dialect_found ? p.dialect_schema : 8'd0;
         end
      end
      pass = 0;
      do begin
         st  = sess_state;
         nx  = st;
         re  = 1'b0;
         ent = sess_entered;
         w   = '0;
         w.unexpected = (pass == 0) ? early : 1'b0;
         // fresh entry into an answering state sends its response
         if (ent && st >= css_pkg::ST_SDP && st <= css_pkg::ST_WELD) begin
            w.resp_valid = 1'b1;
            case (st)
               css_pkg::ST_SDP:  w.resp_type = css_pkg::MSG_SDP;
               css_pkg::ST_SDET: w.resp_type = css_pkg::MSG_SDET;
               css_pkg::ST_PSEL: w.resp_type = css_pkg::MSG_PSEL;
               default: w.resp_type = st;  // remaining codes line up
            endcase
            if (st == css_pkg::ST_SDP) begin
               w.resp_tls = tls_granted;
            end else if (st == css_pkg::ST_APP) begin
               if (dialect_ok) begin
                  w.resp_ok     = 1'b1;
                  w.resp_schema = dialect_schema_q;
               end else begin
                  nx = css_pkg::ST_FAIL;
               end
            end else if (st == css_pkg::ST_SETUP) begin
               session_count = session_count + 64'd1;
            end
            msg = css_pkg::MSG_NONE;
         end
         case (st)
            css_pkg::ST_IDLE: if (p.run) nx = css_pkg::ST_AWAIT;
            css_pkg::ST_AWAIT: begin
               if (msg == css_pkg::MSG_SDP) begin
                  msg = css_pkg::MSG_NONE;
                  nx  = css_pkg::ST_SDP;
               end else if (msg == css_pkg::MSG_V2S) begin
                  w.resp_valid = 1'b1;
                  w.resp_type  = css_pkg::MSG_V2S;
                  msg          = css_pkg::MSG_NONE;
               end
            end
            css_pkg::ST_SDP:   if (msg == css_pkg::MSG_APP) nx = css_pkg::ST_APP;
            css_pkg::ST_APP:   if (msg == css_pkg::MSG_SETUP) nx = css_pkg::ST_SETUP;
            css_pkg::ST_SETUP: if (msg == css_pkg::MSG_SDISC) nx = css_pkg::ST_SDISC;
            css_pkg::ST_SDISC: begin
               if (msg == css_pkg::MSG_PSEL) nx = css_pkg::ST_PSEL;
               if (msg == css_pkg::MSG_SDET) nx = css_pkg::ST_SDET;
            end
            css_pkg::ST_SDET: if (msg == css_pkg::MSG_PSEL) nx = css_pkg::ST_PSEL;
            css_pkg::ST_PSEL: if (msg == css_pkg::MSG_AUTH) nx = css_pkg::ST_AUTH;
            css_pkg::ST_AUTH: begin
               if (msg == css_pkg::MSG_AUTH) re = 1'b1;
               if (msg == css_pkg::MSG_CPD) nx = css_pkg::ST_CPD;
            end
            css_pkg::ST_CPD: begin
               if (msg == css_pkg::MSG_PDEL) nx = css_pkg::ST_PDEL;
               else if (msg == css_pkg::MSG_CABLE) nx = css_pkg::ST_CABLE;
            end
            css_pkg::ST_PDEL: begin
               if (msg == css_pkg::MSG_CPD) nx = css_pkg::ST_CPD;
               if (msg == css_pkg::MSG_CSTAT) nx = css_pkg::ST_CSTAT;
               else if (msg == css_pkg::MSG_STOP) nx = css_pkg::ST_STOP;
               else if (msg == css_pkg::MSG_CDEM) nx = css_pkg::ST_CDEM;
               else if (msg == css_pkg::MSG_WELD) nx = css_pkg::ST_WELD;
            end
            css_pkg::ST_CSTAT: begin
               if (msg == css_pkg::MSG_CSTAT) re = 1'b1;
               if (msg == css_pkg::MSG_PDEL) nx = css_pkg::ST_PDEL;
            end
            css_pkg::ST_STOP: if (!p.client_connected) nx = css_pkg::ST_FIN;
            css_pkg::ST_CABLE: begin
               if (msg == css_pkg::MSG_CABLE) re = 1'b1;
               else if (msg == css_pkg::MSG_PRE) nx = css_pkg::ST_PRE;
            end
            css_pkg::ST_PRE: begin
               if (msg == css_pkg::MSG_PRE) re = 1'b1;
               else if (msg == css_pkg::MSG_PDEL) nx = css_pkg::ST_PDEL;
            end
            css_pkg::ST_CDEM: begin
               if (msg == css_pkg::MSG_CDEM) re = 1'b1;
               else if (msg == css_pkg::MSG_PDEL) nx = css_pkg::ST_PDEL;
            end
            css_pkg::ST_WELD: begin
               if (msg == css_pkg::MSG_WELD) re = 1'b1;
               else if (msg == css_pkg::MSG_STOP) nx = css_pkg::ST_STOP;
            end
            css_pkg::ST_FAIL: begin
               w.close_link = ent;
               w.done_res   = 1'b1;
               if (!p.run) nx = css_pkg::ST_IDLE;
            end
            css_pkg::ST_FIN: begin
               w.done_res = 1'b1;
               if (!p.run) nx = css_pkg::ST_IDLE;
            end
            default: ;
         endcase
         // a message that leads nowhere is cleared and flagged
         if (nx == st && !re && msg != css_pkg::MSG_NONE) begin
            msg          = css_pkg::MSG_NONE;
            w.unexpected = 1'b1;
         end
         // lost link drops every mid-session state into failure
         if (!p.client_connected &&
             !(st == css_pkg::ST_IDLE || st == css_pkg::ST_AWAIT ||
               st == css_pkg::ST_SDP || st == css_pkg::ST_STOP ||
               st == css_pkg::ST_FAIL || st == css_pkg::ST_FIN))
            nx = css_pkg::ST_FAIL;
         sess_entered = re;
         if (nx != st) begin
            sess_entered = 1'b1;
            sess_state   = nx;
         end
         again = sess_entered && pass == 0;
         if (again) msg = css_pkg::MSG_NONE;
         w.session_id = session_count;
         w.state_now  = sess_state;
         w.last       = !again;
         expected_words = {expected_words, w};
         pass++;
      end while (again);
   endfunction

   function automatic void check_field(input string fname, input logic [63:0] exp_val,
                                       input logic [63:0] act_val);
      if (exp_val !== act_val) begin
         err_count++;
         if (err_count <= SHOWN_ERRORS)
            $display("%0t: %s expected %0h, got %0h", $time, fname, exp_val, act_val);
      end
   endfunction

   function automatic css_pkg::css_req_type mk_poll(input bit run, input logic [4:0] msg,
                                                    input bit isreq, input bit client,
                                                    input bit tlsreq, input bit found,
                                                    input logic [7:0] schema);
      css_pkg::css_req_type p;
      p.run              = run;
      p.msg_type         = msg;
      p.msg_is_request   = isreq;
      p.client_connected = client;
      p.tls_requested    = tlsreq;
      p.dialect_found    = found;
      p.dialect_schema   = schema;
      return p;
   endfunction

   // result word with no response attached
   function automatic css_pkg::css_rsp_type quiet_word(input logic [4:0] state,
                                                       input logic [63:0] sid,
                                                       input bit unexp, input bit done,
                                                       input bit closel, input bit last_word);
      css_pkg::css_rsp_type w;
      w            = '0;
      w.state_now  = state;
      w.session_id = sid;
      w.unexpected = unexp;
      w.done_res   = done;
      w.close_link = closel;
      w.last       = last_word;
      return w;
   endfunction

   function automatic void add_row(input css_pkg::css_req_type p, input bit pinned = 1'b0,
                                   input css_pkg::css_rsp_type w = '0);
      dir_row_type r;
      r.poll       = p;
      r.pinned     = pinned;
      r.first_word = w;
      dir_rows = {dir_rows, r};
   endfunction

   // well-formed poll with random side fields
   function automatic css_pkg::css_req_type session_poll(input logic [4:0] msg);
      return mk_poll($urandom_range(7) != 0, msg, 1'b1, 1'b1, 1'($urandom_range(1)),
                     $urandom_range(15) != 0, 8'($urandom_range(255)));
   endfunction

   function automatic css_pkg::css_req_type noise_poll();
      return mk_poll(1'($urandom_range(1)), 5'($urandom_range(31)), 1'($urandom_range(1)),
                     $urandom_range(3) != 0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     8'($urandom_range(255)));
   endfunction

   // one charging session from idle back to idle, sometimes cut short
   function automatic void plan_session();
      logic [4:0]           steps[$];
      css_pkg::css_req_type p;
      int                   cut;
      steps = '{css_pkg::MSG_NONE, css_pkg::MSG_SDP, css_pkg::MSG_APP,
                css_pkg::MSG_SETUP, css_pkg::MSG_SDISC};
      if ($urandom_range(1)) steps = {steps, css_pkg::MSG_SDET};
      steps = {steps, css_pkg::MSG_PSEL};
      repeat ($urandom_range(1, 2)) steps = {steps, css_pkg::MSG_AUTH};
      steps = {steps, css_pkg::MSG_CPD};
      if ($urandom_range(1)) begin
         repeat ($urandom_range(1, 2)) steps = {steps, css_pkg::MSG_CABLE};
         repeat ($urandom_range(1, 2)) steps = {steps, css_pkg::MSG_PRE};
      end
      steps = {steps, css_pkg::MSG_PDEL};
      repeat ($urandom_range(0, 3)) begin
         cut = $urandom_range(2);
         if (cut == 0) begin
            repeat ($urandom_range(1, 2)) steps = {steps, css_pkg::MSG_CSTAT};
         end else if (cut == 1) begin
            repeat ($urandom_range(1, 2)) steps = {steps, css_pkg::MSG_CDEM};
         end else begin
            steps = {steps, css_pkg::MSG_CPD};
         end
         steps = {steps, css_pkg::MSG_PDEL};
      end
      if ($urandom_range(9) < 7)
         repeat ($urandom_range(1, 2)) steps = {steps, css_pkg::MSG_WELD};
      steps = {steps, css_pkg::MSG_STOP};
      // broken session: drop the tail
      if ($urandom_range(9) == 0) begin
         cut = $urandom_range(1, steps.size() - 1);
         while (steps.size() > cut) void'(steps.pop_back());
      end
      foreach (steps[i]) begin
         if ($urandom_range(99) < 3) session_plan = {session_plan, noise_poll()};
         if ($urandom_range(99) < 8)
            session_plan = {session_plan, session_poll(css_pkg::MSG_NONE)};
         p = session_poll(steps[i]);
         if (i == 0) p.run = 1'b1;
         session_plan = {session_plan, p};
      end
      // link drop ends the session, then run low returns to idle
      p = session_poll(css_pkg::MSG_NONE);
      p.run              = 1'b1;
      p.client_connected = 1'b0;
      session_plan = {session_plan, p};
      p = session_poll(css_pkg::MSG_NONE);
      p.run              = 1'b0;
      p.client_connected = 1'($urandom_range(1));
      session_plan = {session_plan, p};
   endfunction

   task automatic send_poll(input css_pkg::css_req_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= p;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // sender holds off until every expected word is back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_tls_cfg(input bit value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      provide_tls_cfg  = value;
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // predict on every accepted poll, check every accepted word
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         words_before = expected_words.size();
         predict_poll(req_bus.data);
         if (polls_taken < dir_rows.size() && dir_rows[polls_taken].pinned)
            expected_words[words_before] = dir_rows[polls_taken].first_word;
         polls_taken++;
      end
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
         got = rsp_bus.data;
         if (expected_words.size() == 0) begin
            err_count++;
            if (err_count <= SHOWN_ERRORS)
               $display("%0t: word with nothing expected, got %h", $time, got);
         end else begin
            want = expected_words.pop_front();
            check_field("resp_valid", 64'(want.resp_valid), 64'(got.resp_valid));
            check_field("resp_type", 64'(want.resp_type), 64'(got.resp_type));
            check_field("resp_ok", 64'(want.resp_ok), 64'(got.resp_ok));
            check_field("resp_tls", 64'(want.resp_tls), 64'(got.resp_tls));
            check_field("resp_schema", 64'(want.resp_schema), 64'(got.resp_schema));
            check_field("session_id", want.session_id, got.session_id);
            check_field("state_now", 64'(want.state_now), 64'(got.state_now));
            check_field("done_res", 64'(want.done_res), 64'(got.done_res));
            check_field("close_link", 64'(want.close_link), 64'(got.close_link));
            check_field("unexpected", 64'(want.unexpected), 64'(got.unexpected));
            check_field("last", 64'(want.last), 64'(got.last));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int ph;
      int sent;
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      rsp_bus.ready = 1'b0;

      // directed: full session through every message but v2s, then a lost link
      add_row(mk_poll(1'b1, css_pkg::MSG_NONE, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00), 1'b1,
              quiet_word(css_pkg::ST_AWAIT, 64'd0, 1'b0, 1'b0, 1'b0, 1'b0));
      add_row(mk_poll(1'b1, css_pkg::MSG_SDP, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
      add_row(mk_poll(1'b1, css_pkg::MSG_APP, 1'b1, 1'b1, 1'b0, 1'b1, 8'hFF));
      add_row(mk_poll(1'b1, css_pkg::MSG_SETUP, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
      add_row(mk_poll(1'b1, css_pkg::MSG_SDISC, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00));
      add_row(mk_poll(1'b1, css_pkg::MSG_SDET, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
      add_row(mk_poll(1'b1, css_pkg::MSG_PSEL, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
      add_row(mk_poll(1'b1, css_pkg::MSG_AUTH, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
      add_row(mk_poll(1'b1, css_pkg::MSG_AUTH, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
      add_row(mk_poll(1'b1, css_pkg::MSG_CPD, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
      add_row(mk_poll(1'b1, css_pkg::MSG_CABLE, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
      add_row(mk_poll(1'b1, css_pkg::MSG_PRE, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
      add_row(mk_poll(1'b1, css_pkg::MSG_PDEL, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
      add_row(mk_poll(1'b1, css_pkg::MSG_CDEM, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
      add_row(mk_poll(1'b1, css_pkg::MSG_PDEL, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
      add_row(mk_poll(1'b1, css_pkg::MSG_CSTAT, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
      add_row(mk_poll(1'b1, css_pkg::MSG_PDEL, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
      add_row(mk_poll(1'b1, css_pkg::MSG_WELD, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
      add_row(mk_poll(1'b1, css_pkg::MSG_STOP, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
      // unknown type is kept and then flagged
      add_row(mk_poll(1'b1, MSG_TOP_CODE, 1'b1, 1'b1, 1'b1, 1'b1, 8'hA5), 1'b1,
              quiet_word(css_pkg::ST_STOP, 64'd1, 1'b1, 1'b0, 1'b0, 1'b1));
      add_row(mk_poll(1'b1, css_pkg::MSG_NONE, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
      // message in finished is dropped on arrival
      add_row(mk_poll(1'b0, css_pkg::MSG_SDP, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00), 1'b1,
              quiet_word(css_pkg::ST_IDLE, 64'd1, 1'b1, 1'b1, 1'b0, 1'b0));
      add_row(mk_poll(1'b1, css_pkg::MSG_NONE, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
      // response mode is dropped, except v2s
      add_row(mk_poll(1'b1, css_pkg::MSG_SETUP, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1,
              quiet_word(css_pkg::ST_AWAIT, 64'd1, 1'b1, 1'b0, 1'b0, 1'b1));
      add_row(mk_poll(1'b1, css_pkg::MSG_V2S, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
      add_row(mk_poll(1'b1, css_pkg::MSG_SDP, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
      add_row(mk_poll(1'b1, css_pkg::MSG_APP, 1'b1, 1'b1, 1'b0, 1'b1, 8'h00));
      // link lost mid-session
      add_row(mk_poll(1'b1, css_pkg::MSG_SETUP, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1,
              quiet_word(css_pkg::ST_FAIL, 64'd1, 1'b0, 1'b0, 1'b0, 1'b0));
      add_row(mk_poll(1'b0, css_pkg::MSG_NONE, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_tls_cfg(1'b1);
      foreach (dir_rows[i]) send_poll(dir_rows[i].poll);
      drain_results();

      // random sessions: free running, sender gaps, receiver stalls, both
      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 55 : (ph == 3) ? 16 : 0;
         rsp_stall_pct = (ph == 2) ? 55 : (ph == 3) ? 16 : 0;
         write_tls_cfg(ph[0]);
         sent = 0;
         while (sent < PHASE_POLLS) begin
            plan_session();
            while (session_plan.size() != 0) begin
               if ($urandom_range(99) == 0) drain_results();
               send_poll(session_plan.pop_front());
               sent++;
            end
         end
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/css_pkg.sv
rtl/css_req_if.sv
rtl/css_rsp_if.sv
rtl/css_pass_logic.sv
rtl/charger_session_sequencer.sv
sim/tb.sv
